### hw/rtl/lfc_pkg.sv
// ----------------------------------------------------------------------------
// LRU file cache directory package
// Shared field widths, operation codes and result status codes.
// ----------------------------------------------------------------------------
package lfc_pkg;

    // Field widths of one beat on each channel.
    localparam int MODE_W  = 3;
    localparam int KEY_W   = 32;
    localparam int SLOT_W  = 4;
    localparam int SIZE_W  = 32;
    localparam int USE_W   = 8;
    localparam int STAT_W  = 3;
    localparam int RANK_W  = 4;
    localparam int CFG_W   = 5;

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [STAT_W-1:0] t_status;

    // Operation codes carried in the mode field.
    localparam t_mode MODE_LOOKUP  = 3'd0;
    localparam t_mode MODE_ALLOC   = 3'd1;
    localparam t_mode MODE_FILL    = 3'd2;
    localparam t_mode MODE_ABANDON = 3'd3;
    localparam t_mode MODE_REFRESH = 3'd4;
    localparam t_mode MODE_USAGE   = 3'd5;
    localparam t_mode MODE_RANK    = 3'd6;

    // Result status codes.
    localparam t_status ST_MISS     = 3'd0;
    localparam t_status ST_PENDING  = 3'd1;
    localparam t_status ST_COMPLETE = 3'd2;
    localparam t_status ST_ALLOC    = 3'd3;
    localparam t_status ST_FULL     = 3'd4;
    localparam t_status ST_DONE     = 3'd5;
    localparam t_status ST_INVALID  = 3'd6;

    // Reset value of the active entries register.
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

endpackage

### hw/rtl/lfc_if.sv
// ----------------------------------------------------------------------------
// LRU file cache directory channels
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface lfc_in_if;
    logic                             valid;
    logic                             ready;
    logic [lfc_pkg::MODE_W-1:0]       mode;
    logic [lfc_pkg::KEY_W-1:0]        key;
    logic [lfc_pkg::SLOT_W-1:0]       slot_in;
    logic [lfc_pkg::SIZE_W-1:0]       fill_size;
    logic [lfc_pkg::USE_W-1:0]        use_count;

    modport source (output valid, mode, key, slot_in, fill_size, use_count, input ready);
    modport sink   (input valid, mode, key, slot_in, fill_size, use_count, output ready);
endinterface

interface lfc_out_if;
    logic                             valid;
    logic                             ready;
    logic [lfc_pkg::STAT_W-1:0]       status;
    logic [lfc_pkg::SLOT_W-1:0]       slot_out;
    logic [lfc_pkg::SIZE_W-1:0]       entry_size;
    logic [lfc_pkg::RANK_W-1:0]       recency_rank;

    modport source (output valid, status, slot_out, entry_size, recency_rank, input ready);
    modport sink   (input valid, status, slot_out, entry_size, recency_rank, output ready);
endinterface

### hw/rtl/lru_file_cache_directory_core.sv
// ----------------------------------------------------------------------------
// LRU file cache directory core
// Slot records in one RAM, read, modified and written back by a sequencer.
// ----------------------------------------------------------------------------
// Lookup and allocate: a search sweep, then a rank sweep, each over every slot;
// a miss or full skips the second.
// Modes 2 to 6: one read-modify-write of the slot (abandon and rank only read it);
// abandon of a slot that is not yet filled adds a rank sweep. One item is in work
// at a time; the next beat can be accepted the cycle after the result is loaded.
// Synchronous reset clears the valid bits, the used-slot count and the sequencer.
module lru_file_cache_directory_core #(
    parameter int SLOTS    = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lfc_pkg::CFG_W-1:0] i_cfg_wdata,
    lfc_in_if.sink                    i_in,
    lfc_out_if.source                 o_out
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef struct packed {
        logic [KEY_BITS-1:0]         key;
        logic                        ready;
        logic [lfc_pkg::SIZE_W-1:0]  size;
        logic [lfc_pkg::USE_W-1:0]   usage;
        logic [SW-1:0]               rank;
    } t_entry;

    localparam int EW = $bits(t_entry);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_RMW  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    // Rank update kinds for the rank sweep.
    localparam logic [1:0] OP_MRU  = 2'd0;
    localparam logic [1:0] OP_TAKE = 2'd1;
    localparam logic [1:0] OP_DROP = 2'd2;

    logic [2:0]                  r_state, n_state;
    lfc_pkg::t_mode              r_mode, n_mode;
    logic [KEY_BITS-1:0]         r_key, n_key;
    logic [SW-1:0]               r_slot, n_slot;
    logic [lfc_pkg::SIZE_W-1:0]  r_fill, n_fill;
    logic [lfc_pkg::USE_W-1:0]   r_use, n_use;
    logic [SW:0]                 r_cnt, n_cnt;
    logic                        r_dv, n_dv;
    logic [SW-1:0]               r_didx, n_didx;
    logic                        r_hit, n_hit;
    logic [SW-1:0]               r_hidx, n_hidx;
    logic [SW-1:0]               r_hrank, n_hrank;
    logic                        r_hready, n_hready;
    logic [lfc_pkg::SIZE_W-1:0]  r_hsize, n_hsize;
    logic                        r_fpick, n_fpick;
    logic [SW-1:0]               r_fidx, n_fidx;
    logic                        r_epick, n_epick;
    logic [SW-1:0]               r_eidx, n_eidx;
    logic [SW-1:0]               r_ebest, n_ebest;
    logic [1:0]                  r_op, n_op;
    logic [SW-1:0]               r_tgt, n_tgt;
    logic [SW-1:0]               r_trank, n_trank;
    logic                        r_newrec, n_newrec;
    logic [SLOTS-1:0]            r_valid, n_valid;
    logic [CW-1:0]               r_used, n_used;
    logic [lfc_pkg::CFG_W-1:0]   r_active, n_active;
    lfc_pkg::t_status            r_rst, n_rst;
    logic [SW-1:0]               r_rslot, n_rslot;
    logic [lfc_pkg::SIZE_W-1:0]  r_rsize, n_rsize;
    logic [SW-1:0]               r_rrank, n_rrank;
    logic                        r_ovalid, n_ovalid;
    lfc_pkg::t_status            r_ost, n_ost;
    logic [lfc_pkg::SLOT_W-1:0]  r_oslot, n_oslot;
    logic [lfc_pkg::SIZE_W-1:0]  r_osize, n_osize;
    logic [lfc_pkg::RANK_W-1:0]  r_orank, n_orank;

    logic                        w_acc;
    logic                        w_slot_ok;
    logic                        w_room;
    logic [31:0]                 w_limit;
    logic                        w_issue;
    logic                        w_last;
    logic                        w_we;
    logic [SW-1:0]               w_waddr;
    logic [SW-1:0]               w_raddr;
    t_entry                      w_wdata;
    t_entry                      w_rd;
    logic [EW-1:0]               w_rdata;

    // Slot record store.
    lfc_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd      = t_entry'(w_rdata);
    assign w_acc     = i_in.valid && i_in.ready;
    assign w_slot_ok = 32'(i_in.slot_in) < SLOTS;
    assign w_limit   = (32'(r_active) < SLOTS) ? 32'(r_active) : SLOTS;
    assign w_room    = 32'(r_used) < w_limit;
    assign w_issue   = r_cnt < (SW + 1)'(SLOTS);
    assign w_last    = r_dv && (r_didx == SW'(SLOTS - 1));

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.status       = r_ost;
    assign o_out.slot_out     = r_oslot;
    assign o_out.entry_size   = r_osize;
    assign o_out.recency_rank = r_orank;

    // Sequencer: search sweep, rank sweep and single-slot updates.
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_key    = r_key;
        n_slot   = r_slot;
        n_fill   = r_fill;
        n_use    = r_use;
        n_cnt    = r_cnt;
        n_dv     = 1'b0;
        n_didx   = r_cnt[SW-1:0];
        n_hit    = r_hit;
        n_hidx   = r_hidx;
        n_hrank  = r_hrank;
        n_hready = r_hready;
        n_hsize  = r_hsize;
        n_fpick  = r_fpick;
        n_fidx   = r_fidx;
        n_epick  = r_epick;
        n_eidx   = r_eidx;
        n_ebest  = r_ebest;
        n_op     = r_op;
        n_tgt    = r_tgt;
        n_trank  = r_trank;
        n_newrec = r_newrec;
        n_valid  = r_valid;
        n_used   = r_used;
        n_active = i_cfg_we ? i_cfg_wdata : r_active;
        n_rst    = r_rst;
        n_rslot  = r_rslot;
        n_rsize  = r_rsize;
        n_rrank  = r_rrank;
        n_ovalid = r_ovalid && !o_out.ready;
        n_ost    = r_ost;
        n_oslot  = r_oslot;
        n_osize  = r_osize;
        n_orank  = r_orank;
        w_we     = 1'b0;
        w_waddr  = r_didx;
        w_wdata  = w_rd;
        w_raddr  = r_cnt[SW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_mode  = i_in.mode;
                    n_key   = KEY_BITS'(i_in.key);
                    n_slot  = SW'(i_in.slot_in);
                    n_fill  = i_in.fill_size;
                    n_use   = i_in.use_count;
                    n_cnt   = '0;
                    n_hit   = 1'b0;
                    n_fpick = 1'b0;
                    n_epick = 1'b0;
                    n_ebest = '0;
                    n_rst   = lfc_pkg::ST_INVALID;
                    n_rslot = '0;
                    n_rsize = '0;
                    n_rrank = '0;
                    if (i_in.mode == lfc_pkg::MODE_LOOKUP ||
                        i_in.mode == lfc_pkg::MODE_ALLOC) begin
                        n_state = S_SCAN;
                    end else if (i_in.mode > lfc_pkg::MODE_RANK || !w_slot_ok ||
                                 !r_valid[SW'(i_in.slot_in)]) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end

            // One slot a cycle: key match, first free slot, best victim.
            S_SCAN: begin
                if (w_issue) begin
                    n_cnt = r_cnt + 1'b1;
                end
                n_dv = w_issue;
                if (r_dv && r_valid[r_didx]) begin
                    if (!r_hit && w_rd.key == r_key) begin
                        n_hit    = 1'b1;
                        n_hidx   = r_didx;
                        n_hrank  = w_rd.rank;
                        n_hready = w_rd.ready;
                        n_hsize  = w_rd.size;
                    end
                    if (w_rd.ready && w_rd.usage == '0 &&
                        (!r_epick || w_rd.rank > r_ebest)) begin
                        n_epick = 1'b1;
                        n_eidx  = r_didx;
                        n_ebest = w_rd.rank;
                    end
                end
                if (r_dv && !r_valid[r_didx] && !r_fpick) begin
                    n_fpick = 1'b1;
                    n_fidx  = r_didx;
                end
                if (w_last) begin
                    n_state = S_DEC;
                end
            end

            // Choose hit, free slot, eviction, miss or full.
            S_DEC: begin
                n_cnt    = '0;
                n_newrec = 1'b0;
                n_state  = S_UPD;
                if (r_hit) begin
                    n_op    = OP_MRU;
                    n_tgt   = r_hidx;
                    n_trank = r_hrank;
                    n_rst   = r_hready ? lfc_pkg::ST_COMPLETE : lfc_pkg::ST_PENDING;
                    n_rslot = r_hidx;
                    n_rsize = r_hready ? r_hsize : '0;
                end else if (r_mode == lfc_pkg::MODE_LOOKUP) begin
                    n_rst   = lfc_pkg::ST_MISS;
                    n_state = S_FIN;
                end else if (w_room && r_fpick) begin
                    n_op     = OP_TAKE;
                    n_tgt    = r_fidx;
                    n_newrec = 1'b1;
                    n_rst    = lfc_pkg::ST_ALLOC;
                    n_rslot  = r_fidx;
                end else if (!w_room && r_epick) begin
                    n_op     = OP_MRU;
                    n_tgt    = r_eidx;
                    n_trank  = r_ebest;
                    n_newrec = 1'b1;
                    n_rst    = lfc_pkg::ST_ALLOC;
                    n_rslot  = r_eidx;
                end else begin
                    n_rst   = lfc_pkg::ST_FULL;
                    n_state = S_FIN;
                end
            end

            // Rewrite ranks one slot a cycle; each slot is written in the cycle after its read.
            S_UPD: begin
                if (w_issue) begin
                    n_cnt = r_cnt + 1'b1;
                end
                n_dv = w_issue;
                if (r_dv) begin
                    if (r_didx == r_tgt) begin
                        w_we = (r_op != OP_DROP);
                        if (r_newrec) begin
                            w_wdata.key   = r_key;
                            w_wdata.ready = 1'b0;
                            w_wdata.size  = '0;
                            w_wdata.usage = '0;
                        end
                        w_wdata.rank = '0;
                    end else if (r_valid[r_didx]) begin
                        w_we = 1'b1;
                        case (r_op)
                            OP_MRU: begin
                                if (w_rd.rank < r_trank) begin
                                    w_wdata.rank = w_rd.rank + 1'b1;
                                end
                            end
                            OP_TAKE: begin
                                w_wdata.rank = w_rd.rank + 1'b1;
                            end
                            OP_DROP: begin
                                if (w_rd.rank > r_trank) begin
                                    w_wdata.rank = w_rd.rank - 1'b1;
                                end
                            end
                            default: begin
                                w_we = 1'b0;
                            end
                        endcase
                    end
                end
                if (w_last) begin
                    n_state = S_FIN;
                    if (r_op == OP_TAKE) begin
                        n_valid[r_tgt] = 1'b1;
                        n_used         = r_used + 1'b1;
                    end else if (r_op == OP_DROP) begin
                        n_valid[r_tgt] = 1'b0;
                        n_used         = r_used - 1'b1;
                    end
                end
            end

            S_RD: begin
                w_raddr = r_slot;
                n_state = S_RMW;
            end

            // Single-slot read-modify-write for modes 2 to 6; abandon and rank do not write here.
            S_RMW: begin
                w_waddr = r_slot;
                n_rst   = lfc_pkg::ST_DONE;
                n_rslot = r_slot;
                n_rrank = w_rd.rank;
                n_state = S_FIN;
                case (r_mode)
                    lfc_pkg::MODE_FILL: begin
                        w_we          = 1'b1;
                        w_wdata.ready = 1'b1;
                        w_wdata.size  = r_fill;
                    end
                    lfc_pkg::MODE_ABANDON: begin
                        n_rrank = '0;
                        if (w_rd.ready) begin
                            n_rst   = lfc_pkg::ST_INVALID;
                            n_rslot = '0;
                        end else begin
                            n_op     = OP_DROP;
                            n_tgt    = r_slot;
                            n_trank  = w_rd.rank;
                            n_newrec = 1'b0;
                            n_cnt    = '0;
                            n_state  = S_UPD;
                        end
                    end
                    lfc_pkg::MODE_REFRESH: begin
                        w_we          = 1'b1;
                        w_wdata.ready = 1'b0;
                        w_wdata.size  = '0;
                        w_wdata.usage = '0;
                    end
                    lfc_pkg::MODE_USAGE: begin
                        w_we          = 1'b1;
                        w_wdata.usage = r_use;
                    end
                    default: begin
                    end
                endcase
            end

            // Hand the result to the output register once it is free.
            S_FIN: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_rst;
                    n_oslot  = lfc_pkg::SLOT_W'(r_rslot);
                    n_osize  = r_rsize;
                    n_orank  = lfc_pkg::RANK_W'(r_rrank);
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_used   <= '0;
            r_active <= lfc_pkg::ACTIVE_RESET;
            r_ovalid <= 1'b0;
            r_dv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_used   <= n_used;
            r_active <= n_active;
            r_ovalid <= n_ovalid;
            r_dv     <= n_dv;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_slot   <= n_slot;
        r_fill   <= n_fill;
        r_use    <= n_use;
        r_cnt    <= n_cnt;
        r_didx   <= n_didx;
        r_hit    <= n_hit;
        r_hidx   <= n_hidx;
        r_hrank  <= n_hrank;
        r_hready <= n_hready;
        r_hsize  <= n_hsize;
        r_fpick  <= n_fpick;
        r_fidx   <= n_fidx;
        r_epick  <= n_epick;
        r_eidx   <= n_eidx;
        r_ebest  <= n_ebest;
        r_op     <= n_op;
        r_tgt    <= n_tgt;
        r_trank  <= n_trank;
        r_newrec <= n_newrec;
        r_rst    <= n_rst;
        r_rslot  <= n_rslot;
        r_rsize  <= n_rsize;
        r_rrank  <= n_rrank;
        r_ost    <= n_ost;
        r_oslot  <= n_oslot;
        r_osize  <= n_osize;
        r_orank  <= n_orank;
    end

endmodule

### hw/rtl/lfc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/lfc_chk.sv
// ----------------------------------------------------------------------------
// LRU file cache directory checker
// Watches the result channel of the core for consistent beats.
// ----------------------------------------------------------------------------
module lfc_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        i_ready,
    input logic [lfc_pkg::STAT_W-1:0]  i_status,
    input logic [lfc_pkg::SLOT_W-1:0]  i_slot,
    input logic [lfc_pkg::SIZE_W-1:0]  i_size,
    input logic [lfc_pkg::RANK_W-1:0]  i_rank
);

    // A result beat stays offered until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result beat dropped before it was taken");

    // No result beat straight after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result beat shown after reset");

    // Only a complete hit carries a size.
    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != lfc_pkg::ST_COMPLETE |-> i_size == '0)
        else $error("size on a beat that is not a complete hit");

    // Miss, full and invalid beats name no slot and no rank.
    a_noslot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == lfc_pkg::ST_MISS || i_status == lfc_pkg::ST_FULL ||
                    i_status == lfc_pkg::ST_INVALID) |-> i_slot == '0 && i_rank == '0)
        else $error("slot or rank on a beat that names no slot");

    // Allocation always leaves the slot most recent.
    a_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == lfc_pkg::ST_ALLOC |-> i_rank == '0)
        else $error("allocated slot not most recent");

endmodule

bind lru_file_cache_directory_core lfc_chk u_lfc_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_status (o_out.status),
    .i_slot   (o_out.slot_out),
    .i_size   (o_out.entry_size),
    .i_rank   (o_out.recency_rank)
);
